FILE: rtl/plas_pkg.sv
// shared types and constants of the polyline arc-length sampler
`timescale 1ns / 1ps
`default_nettype none
package plas_pkg;

  localparam int unsigned COORD_W = 32;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_FEW    = 2'd1;
  localparam logic [1:0] ST_FLAT   = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] cum;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_DIF,
    S_LD_MA,
    S_LD_MB,
    S_LD_SUM,
    S_LD_SQRT,
    S_LD_WR,
    S_Q_RDT,
    S_Q_TOT,
    S_Q_FIRST,
    S_Q_MOD,
    S_Q_SRD,
    S_Q_SCMP,
    S_Q_RDB,
    S_Q_SEG,
    S_Q_DIV,
    S_Q_DIF,
    S_Q_MX,
    S_Q_MY,
    S_Q_FIN,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/plas_mem.sv
// single-port point table with registered read
`timescale 1ns / 1ps
`default_nettype none
module plas_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                 clk_i,
  input  wire                                 we_i,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  plas_pkg::entry_t                    wdata_i,
  output plas_pkg::entry_t                    rdata_o
);

  plas_pkg::entry_t mem_q [DEPTH];
  plas_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/plas_isqrt.sv
// iterative 64-bit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module plas_isqrt (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        act_q;
  logic        done_q;
  logic [35:0] shifted;
  logic [35:0] trial;
  logic        fits;

  assign shifted = {rem_q, rad_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign fits    = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (act_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= fits ? 34'(shifted - trial) : shifted[33:0];
      root_q <= {root_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

FILE: rtl/plas_div.sv
// iterative restoring divider, 64 by 32 bits, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module plas_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] hi_i,
  input  wire  [31:0] lo_i,
  input  wire  [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [4:0]  cnt_q;
  logic        act_q;
  logic        done_q;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem_q, quo_q[31]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      quo_q <= lo_i;
      den_q <= den_i;
    end else if (act_q) begin
      rem_q <= fits ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

FILE: rtl/polyline_arc_length_sampler.sv
// top level of the polyline arc-length sampler
// Usage: a transaction is taken when start_i is high and busy_o is low.
// req_type_i = 0 loads one point (point_x_i, point_y_i, signed Q16.16);
// restart_i = 1 empties the line first. Loads beyond MAX_POINTS are dropped.
// Loads give no result. A load holds busy_o for a table read, the difference,
// two squaring steps, the sum, the square root and the table write. The first
// point of a line goes straight to the write, an overlong segment skips the
// root and a dropped load does not raise busy_o.
// req_type_i = 1 queries the point at arc_pos_i, taken modulo the line length.
// A query gives one result: done_o is high for exactly one cycle with
// pos_x_o, pos_y_o and status_o valid; the receiver cannot stall it.
// A query holds busy_o for a read of the total length, the modulo, a binary
// search on the table read port, the division for the segment fraction and
// two multiply steps. Fewer than two points go straight to the result, and a
// line of zero length skips to its first point.
// All work shares the single table port, so one transaction runs at a time.
// Reset empties the line; table contents are not cleared and need no pass.
`timescale 1ns / 1ps
`default_nettype none
module polyline_arc_length_sampler #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         req_type_i,
  input  wire         restart_i,
  input  wire  [31:0] point_x_i,
  input  wire  [31:0] point_y_i,
  input  wire  [31:0] arc_pos_i,
  output logic        done_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = AW + 1;

  plas_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_eff;
  logic [AW-1:0] lo_q, hi_q, mid;
  logic [31:0]   x_q, y_q, arc_q;
  logic [31:0]   r_q, total_q, c0_q, seg_q, t_q;
  logic [31:0]   p0x_q, p0y_q, p1x_q, p1y_q;
  logic [31:0]   magx_q, magy_q, offx_q, offy_q;
  logic          negx_q, negy_q;
  logic [63:0]   sqa_q, sqb_q;
  logic [31:0]   outx_q, outy_q;
  logic [1:0]    outst_q;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  plas_pkg::entry_t mem_wdata, rd;

  logic          sq_start, sq_done;
  logic [31:0]   sq_root;
  logic [64:0]   sq_sum;
  logic          div_start, div_done;
  logic [31:0]   div_hi, div_lo, div_den, div_quo, div_rem;

  logic          accept;
  logic [32:0]   dx, dy, cum_sum;
  logic [31:0]   arc_mag;

  assign accept  = start_i && (state_q == plas_pkg::S_IDLE);
  assign cnt_eff = restart_i ? '0 : cnt_q;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign sq_sum  = {1'b0, sqa_q} + {1'b0, sqb_q};
  assign cum_sum = {1'b0, c0_q} + {1'b0, seg_q};
  assign arc_mag = arc_q[31] ? (32'd0 - arc_q) : arc_q;

  always_comb begin
    if (state_q == plas_pkg::S_Q_DIF) begin
      dx = {p1x_q[31], p1x_q} - {p0x_q[31], p0x_q};
      dy = {p1y_q[31], p1y_q} - {p0y_q[31], p0y_q};
    end else begin
      dx = {x_q[31], x_q} - {rd.x[31], rd.x};
      dy = {y_q[31], y_q} - {rd.y[31], rd.y};
    end
  end

  plas_mem #(.DEPTH(MAX_POINTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rd)
  );

  plas_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_sum[63:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  plas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plas_pkg::S_IDLE: begin
        if (accept) begin
          if (req_type_i == plas_pkg::REQ_LOAD) begin
            if (cnt_eff >= CW'(MAX_POINTS)) begin
              state_d = plas_pkg::S_IDLE;
            end else if (cnt_eff == '0) begin
              state_d = plas_pkg::S_LD_WR;
            end else begin
              state_d = plas_pkg::S_LD_RD;
            end
          end else if (cnt_q < CW'(2)) begin
            state_d = plas_pkg::S_OUT;
          end else begin
            state_d = plas_pkg::S_Q_RDT;
          end
        end
      end
      plas_pkg::S_LD_RD:   state_d = plas_pkg::S_LD_DIF;
      plas_pkg::S_LD_DIF:  state_d = plas_pkg::S_LD_MA;
      plas_pkg::S_LD_MA:   state_d = plas_pkg::S_LD_MB;
      plas_pkg::S_LD_MB:   state_d = plas_pkg::S_LD_SUM;
      plas_pkg::S_LD_SUM:  state_d = sq_sum[64] ? plas_pkg::S_LD_WR : plas_pkg::S_LD_SQRT;
      plas_pkg::S_LD_SQRT: if (sq_done) state_d = plas_pkg::S_LD_WR;
      plas_pkg::S_LD_WR:   state_d = plas_pkg::S_IDLE;
      plas_pkg::S_Q_RDT:   state_d = plas_pkg::S_Q_TOT;
      plas_pkg::S_Q_TOT:   state_d = (rd.cum == '0) ? plas_pkg::S_Q_FIRST : plas_pkg::S_Q_MOD;
      plas_pkg::S_Q_FIRST: state_d = plas_pkg::S_OUT;
      plas_pkg::S_Q_MOD:   if (div_done) state_d = plas_pkg::S_Q_SRD;
      plas_pkg::S_Q_SRD:   state_d = (lo_q < hi_q) ? plas_pkg::S_Q_SCMP : plas_pkg::S_Q_RDB;
      plas_pkg::S_Q_SCMP:  state_d = plas_pkg::S_Q_SRD;
      plas_pkg::S_Q_RDB:   state_d = plas_pkg::S_Q_SEG;
      plas_pkg::S_Q_SEG:   state_d = plas_pkg::S_Q_DIV;
      plas_pkg::S_Q_DIV:   if (div_done) state_d = plas_pkg::S_Q_DIF;
      plas_pkg::S_Q_DIF:   state_d = plas_pkg::S_Q_MX;
      plas_pkg::S_Q_MX:    state_d = plas_pkg::S_Q_MY;
      plas_pkg::S_Q_MY:    state_d = plas_pkg::S_Q_FIN;
      plas_pkg::S_Q_FIN:   state_d = plas_pkg::S_OUT;
      plas_pkg::S_OUT:     state_d = plas_pkg::S_IDLE;
      default:             state_d = plas_pkg::S_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '{x: x_q, y: y_q, cum: cum_sum[32] ? 32'hFFFF_FFFF : cum_sum[31:0]};
    sq_start  = 1'b0;
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = arc_mag;
    div_den   = rd.cum;
    unique case (state_q)
      plas_pkg::S_LD_RD:  mem_addr = AW'(cnt_q - CW'(1));
      plas_pkg::S_LD_SUM: sq_start = !sq_sum[64];
      plas_pkg::S_LD_WR: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q[AW-1:0];
      end
      plas_pkg::S_Q_RDT:  mem_addr = AW'(cnt_q - CW'(1));
      plas_pkg::S_Q_TOT:  div_start = (rd.cum != '0);
      plas_pkg::S_Q_SRD:  mem_addr = (lo_q < hi_q) ? mid : AW'(lo_q - AW'(1));
      plas_pkg::S_Q_SCMP: mem_addr = mid;
      plas_pkg::S_Q_RDB:  mem_addr = lo_q;
      plas_pkg::S_Q_SEG: begin
        mem_addr  = lo_q;
        div_start = 1'b1;
        div_hi    = r_q - c0_q;
        div_lo    = '0;
        div_den   = rd.cum - c0_q;
      end
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plas_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && req_type_i == plas_pkg::REQ_LOAD) begin
        cnt_q <= cnt_eff;
      end else if (state_q == plas_pkg::S_LD_WR) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      plas_pkg::S_IDLE: begin
        x_q     <= point_x_i;
        y_q     <= point_y_i;
        arc_q   <= arc_pos_i;
        c0_q    <= '0;
        seg_q   <= '0;
        outx_q  <= '0;
        outy_q  <= '0;
        outst_q <= plas_pkg::ST_FEW;
      end
      plas_pkg::S_LD_DIF: begin
        c0_q   <= rd.cum;
        magx_q <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        magy_q <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
      end
      plas_pkg::S_LD_MA:  sqa_q <= magx_q * magx_q;
      plas_pkg::S_LD_MB:  sqb_q <= magy_q * magy_q;
      plas_pkg::S_LD_SUM: seg_q <= 32'hFFFF_FFFF;
      plas_pkg::S_LD_SQRT: if (sq_done) seg_q <= sq_root;
      plas_pkg::S_Q_TOT: begin
        total_q <= rd.cum;
        lo_q    <= AW'(1);
        hi_q    <= AW'(cnt_q - CW'(1));
      end
      plas_pkg::S_Q_FIRST: begin
        outx_q  <= rd.x;
        outy_q  <= rd.y;
        outst_q <= plas_pkg::ST_FLAT;
      end
      plas_pkg::S_Q_MOD: begin
        if (div_done) begin
          r_q <= (arc_q[31] && div_rem != '0) ? total_q - div_rem : div_rem;
        end
      end
      plas_pkg::S_Q_SCMP: begin
        if (rd.cum > r_q) begin
          hi_q <= mid;
        end else begin
          lo_q <= mid + AW'(1);
        end
      end
      plas_pkg::S_Q_RDB: begin
        p0x_q <= rd.x;
        p0y_q <= rd.y;
        c0_q  <= rd.cum;
      end
      plas_pkg::S_Q_SEG: begin
        p1x_q <= rd.x;
        p1y_q <= rd.y;
      end
      plas_pkg::S_Q_DIV: if (div_done) t_q <= div_quo;
      plas_pkg::S_Q_DIF: begin
        negx_q <= dx[32];
        negy_q <= dy[32];
        magx_q <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        magy_q <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
      end
      plas_pkg::S_Q_MX: offx_q <= 32'(({32'd0, magx_q} * {32'd0, t_q}) >> 32);
      plas_pkg::S_Q_MY: offy_q <= 32'(({32'd0, magy_q} * {32'd0, t_q}) >> 32);
      plas_pkg::S_Q_FIN: begin
        outx_q  <= negx_q ? p0x_q - offx_q : p0x_q + offx_q;
        outy_q  <= negy_q ? p0y_q - offy_q : p0y_q + offy_q;
        outst_q <= plas_pkg::ST_INTERP;
      end
      default: begin
      end
    endcase
  end

  assign busy_o   = (state_q != plas_pkg::S_IDLE);
  assign done_o   = (state_q == plas_pkg::S_OUT);
  assign pos_x_o  = outx_q;
  assign pos_y_o  = outy_q;
  assign status_o = outst_q;

endmodule
`default_nettype wire

FILE: dv/polyline_arc_length_sampler_tb.sv
// testbench for the polyline arc-length sampler with a predictive scoreboard
`timescale 1ns / 1ps
module polyline_arc_length_sampler_tb;

  localparam int unsigned MAX_PTS = 1024;

  typedef struct {
    logic        req;
    logic        restart;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] arc;
    bit          drain;
  } txn_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  st;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        req_type_i = plas_pkg::REQ_LOAD;
  logic        restart_i = 1'b0;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic [31:0] arc_pos_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] pos_x_o;
  logic [31:0] pos_y_o;
  logic [1:0]  status_o;

  polyline_arc_length_sampler #(.MAX_POINTS(MAX_PTS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_type_i(req_type_i), .restart_i(restart_i), .point_x_i(point_x_i),
    .point_y_i(point_y_i), .arc_pos_i(arc_pos_i), .done_o(done_o),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .status_o(status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] line_x [MAX_PTS];
  logic [31:0] line_y [MAX_PTS];
  logic [31:0] line_cum [MAX_PTS];
  int unsigned line_cnt = 0;

  txn_t        pending_q[$];
  sample_t     expected_q[$];
  int unsigned errors = 0;
  bit          stim_done = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(longint d);
    return d < 0 ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [63:0] segment_len(longint dx, longint dy);
    logic [63:0] a2, s2;
    a2 = mag(dx) * mag(dx);
    s2 = a2 + mag(dy) * mag(dy);
    if (s2 < a2) return 64'hFFFF_FFFF;
    return isqrt(s2);
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] p0, logic [31:0] p1, logic [63:0] t);
    longint d;
    logic [63:0] off;
    d = longint'($signed(p1)) - longint'($signed(p0));
    off = (mag(d) * t) >> 32;
    return d < 0 ? 32'(longint'($signed(p0)) - longint'(off))
                 : 32'(longint'($signed(p0)) + longint'(off));
  endfunction

  task automatic store_point(logic restart, logic [31:0] px, logic [31:0] py);
    logic [63:0] c;
    if (restart) line_cnt = 0;
    if (line_cnt >= MAX_PTS) return;
    line_x[line_cnt] = px;
    line_y[line_cnt] = py;
    if (line_cnt == 0) begin
      line_cum[0] = 0;
    end else begin
      c = 64'(line_cum[line_cnt-1]) + segment_len(
        longint'($signed(px)) - longint'($signed(line_x[line_cnt-1])),
        longint'($signed(py)) - longint'($signed(line_y[line_cnt-1])));
      line_cum[line_cnt] = c > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : c[31:0];
    end
    line_cnt++;
  endtask

  function automatic sample_t sample_at(logic [31:0] arc);
    sample_t s;
    longint total, rs;
    logic [63:0] r, c0, seg, t;
    int unsigned lo, hi, mid;
    if (line_cnt < 2) begin
      s.x = 0; s.y = 0; s.st = plas_pkg::ST_FEW;
      return s;
    end
    total = longint'(line_cum[line_cnt-1]);
    if (total == 0) begin
      s.x = line_x[0]; s.y = line_y[0]; s.st = plas_pkg::ST_FLAT;
      return s;
    end
    rs = longint'($signed(arc)) % total;
    if (rs < 0) rs += total;
    r = 64'(rs);
    lo = 1;
    hi = line_cnt - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (64'(line_cum[mid]) > r) hi = mid;
      else lo = mid + 1;
    end
    c0 = 64'(line_cum[lo-1]);
    seg = 64'(line_cum[lo]) - c0;
    t = seg != 0 ? ((r - c0) << 32) / seg : 0;
    s.x = lerp(line_x[lo-1], line_x[lo], t);
    s.y = lerp(line_y[lo-1], line_y[lo], t);
    s.st = plas_pkg::ST_INTERP;
    return s;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] rand_coord(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 16;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic push(logic req, logic restart, logic [31:0] px, logic [31:0] py,
                      logic [31:0] arc);
    txn_t tr;
    tr.req = req; tr.restart = restart; tr.px = px; tr.py = py; tr.arc = arc;
    tr.drain = 1'b0;
    pending_q.insert(pending_q.size(), tr);
  endtask

  task automatic push_drain();
    txn_t tr;
    tr = '{default: '0};
    tr.drain = 1'b1;
    pending_q.insert(pending_q.size(), tr);
  endtask

  // driver: bursts and gaps; a drain entry holds off until all results are in
  logic        driving = 1'b0;
  int unsigned gap = 0;
  int unsigned burst = 0;
  txn_t        cur;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (driving && !busy_o) begin
        if (cur.req == plas_pkg::REQ_LOAD) store_point(cur.restart, cur.px, cur.py);
        else expected_q.insert(expected_q.size(), sample_at(cur.arc));
      end
      if (driving && busy_o) begin
        // keep holding the transaction
      end else if (gap != 0) begin
        gap <= gap - 1;
        driving <= 1'b0;
        start_i <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && (expected_q.size() != 0 || busy_o))) begin
        cur = pending_q.pop_front();
        if (cur.drain) begin
          driving <= 1'b0;
          start_i <= 1'b0;
        end else begin
          driving <= 1'b1;
          start_i <= 1'b1;
          req_type_i <= cur.req;
          restart_i <= cur.restart;
          point_x_i <= cur.px;
          point_y_i <= cur.py;
          arc_pos_i <= cur.arc;
          if (burst == 0) begin
            burst <= $urandom_range(0, 12);
            gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst <= burst - 1;
          end
        end
      end else begin
        driving <= 1'b0;
        start_i <= 1'b0;
        if (pending_q.size() == 0 && !driving) stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report("unexpected result pos_x", pos_x_o, 0);
      end else begin
        e = expected_q.pop_front();
        if (pos_x_o !== e.x) report("pos_x", pos_x_o, e.x);
        if (pos_y_o !== e.y) report("pos_y", pos_y_o, e.y);
        if (status_o !== e.st) report("status", 32'(status_o), 32'(e.st));
      end
    end
  end

  initial begin
    int unsigned n, len, mode, sent;
    logic [31:0] bx, by;
    // directed
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h8000_0000);
    push(plas_pkg::REQ_LOAD, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 0);
    push(plas_pkg::REQ_QUERY, 1'b1, 0, 0, 32'h7FFF_FFFF);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 0);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h1234_5678);
    push(plas_pkg::REQ_LOAD, 1'b1, 32'h8000_0000, 32'h8000_0000, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h0000_0000);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'hFFFF_FFFF);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h8000_0000);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h7FFF_FFFF);
    push(plas_pkg::REQ_LOAD, 1'b1, 0, 0, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h0003_0000, 0, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h0003_0000, 0, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h0003_0000, 32'h0004_0000, 0);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h0003_0000);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h0004_8000);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'hFFFF_0000);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, 32'h0008_0000);
    push_drain();
    // fill past capacity, including a zero-length line at the end
    push(plas_pkg::REQ_LOAD, 1'b1, 32'h0000_1000, 32'h0000_2000, 0);
    for (int i = 1; i < MAX_PTS + 3; i++)
      push(plas_pkg::REQ_LOAD, 1'b0, (i < 1000) ? 32'(i * 7919) : 32'h0000_1000,
           (i < 1000) ? 32'(-i * 104729) : 32'h0000_2000, 0);
    for (int i = 0; i < 20; i++)
      push(plas_pkg::REQ_QUERY, $urandom_range(0, 1), 0, 0, $urandom);
    push(plas_pkg::REQ_LOAD, 1'b1, 32'h0000_1000, 32'h0000_2000, 0);
    push(plas_pkg::REQ_LOAD, 1'b0, 32'h0000_1000, 32'h0000_2000, 0);
    push(plas_pkg::REQ_QUERY, 1'b0, 0, 0, $urandom);
    push_drain();
    // random lines with queries, plus noise
    sent = 0;
    while (sent < 250) begin
      mode = $urandom_range(0, 2);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 12);
      bx = rand_coord(mode);
      by = rand_coord(mode);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          push(plas_pkg::REQ_LOAD, i == 0, bx, by, 0);
        end else begin
          push(plas_pkg::REQ_LOAD, i == 0, rand_coord(mode), rand_coord(mode), 0);
        end
        sent++;
      end
      if (len == 0 && $urandom_range(0, 1))
        push(plas_pkg::REQ_LOAD, 1'b1, $urandom, $urandom, 0);
      n = $urandom_range(2, 10);
      for (int i = 0; i < n; i++) begin
        push(plas_pkg::REQ_QUERY, $urandom_range(0, 1), $urandom, $urandom,
             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22));
        sent++;
      end
      if ($urandom_range(0, 20) == 0) push_drain();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
